/* design/qstc_pkg.sv */
package qstc_pkg;

  // field widths
  localparam int CODE_W = 15;
  localparam int COMP_W = 16;
  localparam int MAG_W  = 30;
  localparam int ROOT_W = 31;
  localparam int SQ_W   = 62;
  localparam int NUM_W  = 46;
  localparam int QUO_W  = 15;

  // pipeline depths of the two square roots and the divider
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = QUO_W;

  // fixed-point constants
  localparam logic [CODE_W-1:0] MAXQ         = '1;
  localparam logic [24:0]       SQRT2_Q24    = 25'd23726566;
  localparam logic [29:0]       INVSQRT2_Q30 = 30'd759250125;
  localparam logic [SQ_W-1:0]   ONE_Q60      = 62'd1 << 60;

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_e;

  // per-item data carried along the back half of the pipeline
  typedef struct packed {
    func_e                         func;
    logic [1:0]                    drop;
    logic [2:0]                    neg;
    logic [2:0][MAG_W-1:0]         mag;
    logic [2:0][CODE_W-1:0]        code;
  } pass_t;

  // one square root stage
  typedef struct packed {
    pass_t           p;
    logic [SQ_W-1:0] aux;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } rt_t;

  // one divider stage, four lanes
  typedef struct packed {
    pass_t                   p;
    logic [3:0]              neg;
    logic [ROOT_W:0]         den;
    logic [3:0][NUM_W-1:0]   rem;
    logic [3:0][QUO_W-1:0]   quo;
  } dv_t;

  // one digit of the bitwise integer square root
  function automatic rt_t rt_step(input rt_t a, input logic [SQ_W-1:0] b);
    rt_t             r;
    logic [SQ_W-1:0] t;
    r = a;
    t = a.res + b;
    if (a.rem >= t) begin
      r.rem = a.rem - t;
      r.res = (a.res >> 1) + b;
    end else begin
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  // one quotient bit of restoring division in all four lanes
  function automatic dv_t dv_step(input dv_t a, input int sh);
    dv_t              r;
    logic [NUM_W-1:0] dn;
    r  = a;
    dn = NUM_W'(a.den) << sh;
    for (int i = 0; i < 4; i++) begin
      if (a.rem[i] >= dn) begin
        r.rem[i]     = a.rem[i] - dn;
        r.quo[i][sh] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

/* design/quaternion_smallest_three_codec.sv */
// Smallest-three quaternion codec, encode and decode in one 88-stage pipeline.
// An item is taken whenever start is high; busy stays low, so one item can
// enter every clock cycle, and its result shows on the outputs with done_o
// high for a single cycle. The pipeline depth is set by the decode path:
// two 32-stage bitwise square roots (the dropped component, then the
// length) and a 16-stage divider for the renormalization; encode items
// travel the same pipe so results leave in order. Results cannot be held
// off: a receiver must take each one in the cycle done_o is high. Fields
// that the chosen function does not produce are driven as zero.
module quaternion_smallest_three_codec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func_i,
  input  logic [qstc_pkg::COMP_W-1:0]    comp_x_i,
  input  logic [qstc_pkg::COMP_W-1:0]    comp_y_i,
  input  logic [qstc_pkg::COMP_W-1:0]    comp_z_i,
  input  logic [qstc_pkg::COMP_W-1:0]    comp_w_i,
  input  logic [1:0]                     dropped_index_in_i,
  input  logic [qstc_pkg::CODE_W-1:0]    code_first_in_i,
  input  logic [qstc_pkg::CODE_W-1:0]    code_second_in_i,
  input  logic [qstc_pkg::CODE_W-1:0]    code_third_in_i,
  output logic                           done_o,
  output logic [1:0]                     dropped_index_out_o,
  output logic [qstc_pkg::CODE_W-1:0]    code_first_out_o,
  output logic [qstc_pkg::CODE_W-1:0]    code_second_out_o,
  output logic [qstc_pkg::CODE_W-1:0]    code_third_out_o,
  output logic [qstc_pkg::COMP_W-1:0]    quat_x_o,
  output logic [qstc_pkg::COMP_W-1:0]    quat_y_o,
  output logic [qstc_pkg::COMP_W-1:0]    quat_z_o,
  output logic [qstc_pkg::COMP_W-1:0]    quat_w_o
);
  import qstc_pkg::*;

  localparam logic signed [41:0] ENC_HALF = 42'sh4000000000;
  localparam logic signed [41:0] ENC_TOP  = 42'sh8000000000;
  localparam logic [54:0]        RND_HALF = 55'h4000000000;
  localparam logic [17:0]        MAXQ_1   = 18'(MAXQ);
  localparam logic [17:0]        MAXQ_2   = 18'(MAXQ) << 1;

  // valid bits, one per stage
  logic                  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic [SQRT_STEPS:0]   sqa_vld_q;
  logic                  dq_vld_q;
  logic [SQRT_STEPS:0]   sqb_vld_q;
  logic [DIV_STEPS:0]    dv_vld_q;
  logic                  out_vld_q;

  // stage 1: encode selection, decode code unfolding
  logic [3:0][COMP_W-1:0]   cin;
  logic [3:0][COMP_W:0]     amag;
  logic [1:0]               big_d;
  logic [COMP_W:0]          best;
  logic [2:0][COMP_W:0]     s1_a_d, s1_a_q;
  logic [2:0][CODE_W-1:0]   cde;
  logic [2:0][CODE_W-1:0]   s1_nm_d, s1_nm_q;
  logic [2:0]               s1_nn_d, s1_nn_q;
  logic [1:0]               s1_drop_d, s1_drop_q;
  func_e                    s1_func_q;
  logic [1:0]               kidx;
  logic [COMP_W-1:0]        ksel;

  assign cin = {comp_w_i, comp_z_i, comp_y_i, comp_x_i};
  assign cde = {code_third_in_i, code_second_in_i, code_first_in_i};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      amag[i] = cin[i][COMP_W-1] ? ((COMP_W+1)'(0) - {1'b1, cin[i]}) : {1'b0, cin[i]};
    end
    big_d = 2'd0;
    best  = amag[0];
    for (int i = 1; i < 4; i++) begin
      if (amag[i] > best) begin
        best  = amag[i];
        big_d = 2'(i);
      end
    end
    kidx = 2'd0;
    ksel = '0;
    for (int k = 0; k < 3; k++) begin
      kidx      = (2'(k) < big_d) ? 2'(k) : 2'(k + 1);
      ksel      = cin[kidx];
      s1_a_d[k] = cin[big_d][COMP_W-1] ? ((COMP_W+1)'(0) - {ksel[COMP_W-1], ksel})
                                        : {ksel[COMP_W-1], ksel};
      // |2*code - MAXQ| and its sign
      s1_nm_d[k] = {cde[k][CODE_W-1] ? cde[k][CODE_W-2:0] : ~cde[k][CODE_W-2:0], 1'b1};
      s1_nn_d[k] = ~cde[k][CODE_W-1];
    end
    s1_drop_d = (func_i == FUNC_DEC) ? dropped_index_in_i : big_d;
  end

  always_ff @(posedge clk_i) begin
    s1_a_q    <= s1_a_d;
    s1_nm_q   <= s1_nm_d;
    s1_nn_q   <= s1_nn_d;
    s1_drop_q <= s1_drop_d;
    s1_func_q <= func_e'(func_i);
  end

  // stage 2: the scaling multiplies
  logic [2:0][41:0]   s2_s_d, s2_s_q;
  logic [2:0][45:0]   s2_x_d, s2_x_q;
  logic [2:0]         s2_nn_q;
  logic [1:0]         s2_drop_q;
  func_e              s2_func_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_s_d[k] = $signed(s1_a_q[k]) * $signed({1'b0, SQRT2_Q24}) + ENC_HALF;
      s2_x_d[k] = 46'(s1_nm_q[k]) * 46'(INVSQRT2_Q30) + 46'(MAXQ >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_s_q    <= s2_s_d;
    s2_x_q    <= s2_x_d;
    s2_nn_q   <= s1_nn_q;
    s2_drop_q <= s1_drop_q;
    s2_func_q <= s1_func_q;
  end

  // stage 3: clamp and round to codes, first fold of the divide by MAXQ
  logic [2:0][CODE_W-1:0] s3_code_d, s3_code_q;
  logic [2:0][30:0]       s3_q1_d, s3_q1_q;
  logic [2:0][31:0]       s3_r1_d, s3_r1_q;
  logic [2:0]             s3_nn_q;
  logic [1:0]             s3_drop_q;
  func_e                  s3_func_q;
  logic [39:0]            sc;
  logic [54:0]            rt;

  always_comb begin
    sc = '0;
    rt = '0;
    for (int k = 0; k < 3; k++) begin
      if ($signed(s2_s_q[k]) < 0) begin
        sc = '0;
      end else if ($signed(s2_s_q[k]) > ENC_TOP) begin
        sc = ENC_TOP[39:0] | 40'h80_0000_0000;
      end else begin
        sc = s2_s_q[k][39:0];
      end
      rt           = (55'(sc) << CODE_W) - 55'(sc) + RND_HALF;
      s3_code_d[k] = rt[53:39];
      s3_q1_d[k]   = s2_x_q[k][45:15];
      s3_r1_d[k]   = {1'b0, s2_x_q[k][45:15]} + 32'(s2_x_q[k][14:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    s3_code_q <= s3_code_d;
    s3_q1_q   <= s3_q1_d;
    s3_r1_q   <= s3_r1_d;
    s3_nn_q   <= s2_nn_q;
    s3_drop_q <= s2_drop_q;
    s3_func_q <= s2_func_q;
  end

  // stage 4: second fold of the divide by MAXQ
  logic [2:0][30:0]       s4_q2_d, s4_q2_q;
  logic [2:0][17:0]       s4_r2_d, s4_r2_q;
  logic [2:0][CODE_W-1:0] s4_code_q;
  logic [2:0]             s4_nn_q;
  logic [1:0]             s4_drop_q;
  func_e                  s4_func_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_q2_d[k] = s3_q1_q[k] + 31'(s3_r1_q[k][31:15]);
      s4_r2_d[k] = 18'(s3_r1_q[k][31:15]) + 18'(s3_r1_q[k][14:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q2_q   <= s4_q2_d;
    s4_r2_q   <= s4_r2_d;
    s4_code_q <= s3_code_q;
    s4_nn_q   <= s3_nn_q;
    s4_drop_q <= s3_drop_q;
    s4_func_q <= s3_func_q;
  end

  // stage 5: final remainder correction gives the kept magnitudes
  pass_t s5_d, s5_q;

  always_comb begin
    s5_d.func = s4_func_q;
    s5_d.drop = s4_drop_q;
    s5_d.neg  = s4_nn_q;
    s5_d.code = s4_code_q;
    for (int k = 0; k < 3; k++) begin
      s5_d.mag[k] = MAG_W'(s4_q2_q[k] + 31'(s4_r2_q[k] >= MAXQ_1)
                          + 31'(s4_r2_q[k] >= MAXQ_2));
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q <= s5_d;
  end

  // stage 6: squares of the kept magnitudes
  pass_t                 s6_q;
  logic [2:0][SQ_W-3:0]  s6_sq_q;

  always_ff @(posedge clk_i) begin
    s6_q <= s5_q;
    for (int k = 0; k < 3; k++) begin
      s6_sq_q[k] <= (SQ_W-2)'(s5_q.mag[k]) * (SQ_W-2)'(s5_q.mag[k]);
    end
  end

  // square root of one minus the sum, one digit per stage
  rt_t             sqa_q [SQRT_STEPS+1];
  rt_t             sqa_d;
  logic [SQ_W-1:0] sum;

  always_comb begin
    sum       = SQ_W'(s6_sq_q[0]) + SQ_W'(s6_sq_q[1]) + SQ_W'(s6_sq_q[2]);
    sqa_d.p   = s6_q;
    sqa_d.aux = sum;
    sqa_d.rem = (sum < ONE_Q60) ? (ONE_Q60 - sum) : '0;
    sqa_d.res = '0;
  end

  always_ff @(posedge clk_i) begin
    sqa_q[0] <= sqa_d;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      sqa_q[j+1] <= rt_step(sqa_q[j], SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j)));
    end
  end

  // square of the rebuilt component
  pass_t             dq_p_q;
  logic [ROOT_W-1:0] dq_d_q;
  logic [SQ_W-1:0]   dq_sum_q;
  logic [SQ_W-1:0]   dq_sq_q;

  always_ff @(posedge clk_i) begin
    dq_p_q   <= sqa_q[SQRT_STEPS].p;
    dq_d_q   <= sqa_q[SQRT_STEPS].res[ROOT_W-1:0];
    dq_sum_q <= sqa_q[SQRT_STEPS].aux;
    dq_sq_q  <= SQ_W'(sqa_q[SQRT_STEPS].res[ROOT_W-1:0])
                * SQ_W'(sqa_q[SQRT_STEPS].res[ROOT_W-1:0]);
  end

  // square root of the length squared
  rt_t sqb_q [SQRT_STEPS+1];
  rt_t sqb_d;

  always_comb begin
    sqb_d.p   = dq_p_q;
    sqb_d.aux = SQ_W'(dq_d_q);
    sqb_d.rem = dq_sum_q + dq_sq_q;
    sqb_d.res = '0;
  end

  always_ff @(posedge clk_i) begin
    sqb_q[0] <= sqb_d;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      sqb_q[j+1] <= rt_step(sqb_q[j], SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j)));
    end
  end

  // renormalize: four lanes of restoring division by twice the length
  dv_t               dv_q [DIV_STEPS+1];
  dv_t               dv_d;
  rt_t               sqb_last;
  logic [ROOT_W-1:0] len;
  logic [ROOT_W-1:0] mlane;
  logic [1:0]        klane;

  always_comb begin
    sqb_last = sqb_q[SQRT_STEPS];
    len      = sqb_last.res[ROOT_W-1:0];
    dv_d.p   = sqb_last.p;
    dv_d.den = {len, 1'b0};
    dv_d.quo = '0;
    mlane    = '0;
    klane    = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) == sqb_last.p.drop) begin
        mlane       = sqb_last.aux[ROOT_W-1:0];
        dv_d.neg[i] = 1'b0;
      end else begin
        klane       = (2'(i) < sqb_last.p.drop) ? 2'(i) : 2'(i - 1);
        mlane       = ROOT_W'(sqb_last.p.mag[klane]);
        dv_d.neg[i] = sqb_last.p.neg[klane];
      end
      dv_d.rem[i] = {mlane, {(NUM_W-ROOT_W){1'b0}}} + NUM_W'(len);
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv_d;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_q[j+1] <= dv_step(dv_q[j], DIV_STEPS - 1 - j);
    end
  end

  // output register, unused fields forced to zero
  logic [1:0]               out_drop_q;
  logic [2:0][CODE_W-1:0]   out_code_q;
  logic [3:0][COMP_W-1:0]   out_quat_q;
  dv_t                      dv_last;

  assign dv_last = dv_q[DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (dv_last.p.func == FUNC_DEC) begin
      out_drop_q <= '0;
      out_code_q <= '0;
      for (int i = 0; i < 4; i++) begin
        out_quat_q[i] <= dv_last.neg[i] ? (COMP_W'(0) - {1'b0, dv_last.quo[i]})
                                        : {1'b0, dv_last.quo[i]};
      end
    end else begin
      out_drop_q <= dv_last.p.drop;
      out_code_q <= dv_last.p.code;
      out_quat_q <= '0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      sqa_vld_q <= '0;
      dq_vld_q  <= 1'b0;
      sqb_vld_q <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      sqa_vld_q <= {sqa_vld_q[SQRT_STEPS-1:0], s6_vld_q};
      dq_vld_q  <= sqa_vld_q[SQRT_STEPS];
      sqb_vld_q <= {sqb_vld_q[SQRT_STEPS-1:0], dq_vld_q};
      dv_vld_q  <= {dv_vld_q[DIV_STEPS-1:0], sqb_vld_q[SQRT_STEPS]};
      out_vld_q <= dv_vld_q[DIV_STEPS];
    end
  end

  assign busy                = 1'b0;
  assign done_o              = out_vld_q;
  assign dropped_index_out_o = out_drop_q;
  assign code_first_out_o    = out_code_q[0];
  assign code_second_out_o   = out_code_q[1];
  assign code_third_out_o    = out_code_q[2];
  assign quat_x_o            = out_quat_q[0];
  assign quat_y_o            = out_quat_q[1];
  assign quat_z_o            = out_quat_q[2];
  assign quat_w_o            = out_quat_q[3];

endmodule

/* tb/sv/qstc_checker.sv */
// watches the codec channels, predicts each result and compares
module qstc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        func_i,
  input  logic [qstc_pkg::COMP_W-1:0] comp_x_i,
  input  logic [qstc_pkg::COMP_W-1:0] comp_y_i,
  input  logic [qstc_pkg::COMP_W-1:0] comp_z_i,
  input  logic [qstc_pkg::COMP_W-1:0] comp_w_i,
  input  logic [1:0]                  dropped_index_in_i,
  input  logic [qstc_pkg::CODE_W-1:0] code_first_in_i,
  input  logic [qstc_pkg::CODE_W-1:0] code_second_in_i,
  input  logic [qstc_pkg::CODE_W-1:0] code_third_in_i,
  input  logic                        done_o,
  input  logic [1:0]                  dropped_index_out_o,
  input  logic [qstc_pkg::CODE_W-1:0] code_first_out_o,
  input  logic [qstc_pkg::CODE_W-1:0] code_second_out_o,
  input  logic [qstc_pkg::CODE_W-1:0] code_third_out_o,
  input  logic [qstc_pkg::COMP_W-1:0] quat_x_o,
  input  logic [qstc_pkg::COMP_W-1:0] quat_y_o,
  input  logic [qstc_pkg::COMP_W-1:0] quat_z_o,
  input  logic [qstc_pkg::COMP_W-1:0] quat_w_o,
  output int                          pending,
  output int                          errors
);
  import qstc_pkg::*;

  typedef struct packed {
    logic [1:0]             drop;
    logic [2:0][CODE_W-1:0] code;
    logic [3:0][COMP_W-1:0] quat;
  } codec_res_t;

  localparam longint unsigned MAXQ_L = 64'd32767;
  localparam longint unsigned EPS_L  = 64'd1152921;

  codec_res_t outstanding_q[$];

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one component onto a code
  function automatic logic [CODE_W-1:0] code_of(input longint a);
    longint s, half, top;
    longint unsigned q;
    half = 64'sd1 << 38;
    top  = 64'sd1 << 39;
    s = a * 64'sd23726566 + half;
    if (s < 0) s = 0;
    if (s > top) s = top;
    q = (longint'(s) * MAXQ_L + half) >> 39;
    return q[CODE_W-1:0];
  endfunction

  // Q30 component back to Q2.14, rounded and saturated
  function automatic logic [COMP_W-1:0] comp_out(input longint c,
      input longint unsigned len, input bit use_len);
    longint unsigned mag, r;
    mag = (c < 0) ? -c : c;
    if (use_len) r = ((mag << 15) + len) / (len << 1);
    else         r = ((mag << 14) + (64'd1 << 29)) >> 30;
    if (c < 0) begin
      if (r > 32768) r = 32768;
      return COMP_W'(-r);
    end
    if (r > 32767) r = 32767;
    return r[COMP_W-1:0];
  endfunction

  function automatic codec_res_t predict_codec(input func_e fn,
      input logic [3:0][COMP_W-1:0] comps, input logic [1:0] drop_in,
      input logic [2:0][CODE_W-1:0] codes_in);
    codec_res_t r;
    longint c[4];
    longint v[4];
    longint best, m, n, sgn;
    longint unsigned mag, sum, lensq, len;
    int big, k;
    bit use_len;
    r = '0;
    if (fn == FUNC_ENC) begin
      for (int i = 0; i < 4; i++) c[i] = longint'($signed(comps[i]));
      big  = 0;
      best = c[0] < 0 ? -c[0] : c[0];
      for (int i = 1; i < 4; i++) begin
        m = c[i] < 0 ? -c[i] : c[i];
        if (m > best) begin
          best = m;
          big  = i;
        end
      end
      sgn = c[big] < 0 ? -1 : 1;
      r.drop = big[1:0];
      k = 0;
      for (int i = 0; i < 4; i++) begin
        if (i != big) begin
          r.code[k] = code_of(c[i] * sgn);
          k++;
        end
      end
    end else begin
      sum = 0;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        v[i] = 0;
        if (i != drop_in) begin
          n = 2 * longint'(codes_in[k]) - longint'(MAXQ_L);
          k++;
          mag = (n < 0 ? -n : n) * 64'd759250125;
          mag = (mag + MAXQ_L / 2) / MAXQ_L;
          v[i] = n < 0 ? -longint'(mag) : longint'(mag);
          sum += mag * mag;
        end
      end
      v[drop_in] = (sum < (64'd1 << 60)) ? longint'(int_sqrt((64'd1 << 60) - sum)) : 0;
      lensq   = sum + longint'(v[drop_in]) * longint'(v[drop_in]);
      use_len = lensq > EPS_L;
      len     = use_len ? int_sqrt(lensq) : 0;
      if (len == 0) use_len = 0;
      for (int i = 0; i < 4; i++) r.quat[i] = comp_out(v[i], len, use_len);
    end
    return r;
  endfunction

  // predict on accepted items, compare on strobed results
  always @(posedge clk_i or negedge rst_ni) begin
    codec_res_t want, got;
    if (!rst_ni) begin
      outstanding_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (start && !busy)
        outstanding_q.push_back(predict_codec(func_e'(func_i),
            {comp_w_i, comp_z_i, comp_y_i, comp_x_i}, dropped_index_in_i,
            {code_third_in_i, code_second_in_i, code_first_in_i}));
      if (done_o) begin
        got.drop = dropped_index_out_o;
        got.code = {code_third_out_o, code_second_out_o, code_first_out_o};
        got.quat = {quat_w_o, quat_z_o, quat_y_o, quat_x_o};
        if (outstanding_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = outstanding_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: drop %0d/%0d codes %h/%h quat %h/%h",
                       want.drop, got.drop, want.code, got.code,
                       want.quat, got.quat);
          end
        end
      end
      pending = outstanding_q.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
// stimulus and verdict for the smallest-three codec
module tb;
  import qstc_pkg::*;

  localparam int LATENCY   = 88;
  localparam int MAX_TICKS = 400000;

  logic              clk_i, rst_ni, start, busy, func_i, done_o;
  logic [COMP_W-1:0] comp_x_i, comp_y_i, comp_z_i, comp_w_i;
  logic [1:0]        dropped_index_in_i, dropped_index_out_o;
  logic [CODE_W-1:0] code_first_in_i, code_second_in_i, code_third_in_i;
  logic [CODE_W-1:0] code_first_out_o, code_second_out_o, code_third_out_o;
  logic [COMP_W-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  int                pending, errors, ticks, idle_pct;

  quaternion_smallest_three_codec DUT (.*);
  qstc_checker checker_i (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    ticks = 0;
    forever begin
      @(posedge clk_i);
      ticks++;
      if (ticks > MAX_TICKS) begin
        $display("** quaternion_smallest_three_codec: FAILED **");
        $finish;
      end
    end
  end

  // drive one item, holding until accepted
  task automatic send_item(input func_e fn, input logic [3:0][COMP_W-1:0] q,
      input logic [1:0] drop, input logic [2:0][CODE_W-1:0] codes);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start              <= 1'b1;
    func_i             <= fn;
    {comp_w_i, comp_z_i, comp_y_i, comp_x_i} <= q;
    dropped_index_in_i <= drop;
    {code_third_in_i, code_second_in_i, code_first_in_i} <= codes;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(3))
      0:       return COMP_W'($urandom);
      1:       return COMP_W'(int'($urandom_range(32768)) - 16384);
      2:       return COMP_W'(int'($urandom_range(23170)) - 11585);
      default: return COMP_W'(int'($urandom_range(400)) - 200);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    case ($urandom_range(3))
      0:       return CODE_W'($urandom);
      1:       return MAXQ;
      2:       return '0;
      default: return CODE_W'(16384 + int'($urandom_range(64)) - 32);
    endcase
  endfunction

  initial begin
    logic [3:0][COMP_W-1:0] q;
    logic [2:0][CODE_W-1:0] cd;
    start = 0; func_i = 0; comp_x_i = 0; comp_y_i = 0; comp_z_i = 0; comp_w_i = 0;
    dropped_index_in_i = 0; code_first_in_i = 0; code_second_in_i = 0;
    code_third_in_i = 0; rst_ni = 0; idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, ties, zero quaternion, every dropped index
    send_item(FUNC_ENC, '0, 2'd0, '0);
    send_item(FUNC_ENC, {4{16'sd16384}}, 2'd0, '0);
    send_item(FUNC_ENC, {16'sd0, 16'sd0, -16'sd16384, 16'sd0}, 2'd0, '0);
    send_item(FUNC_ENC, {16'h8000, 16'h7fff, 16'h7fff, 16'h8000}, 2'd0, '0);
    send_item(FUNC_ENC, {16'sd11585, -16'sd11585, 16'sd11586, -16'sd11586}, 2'd0, '0);
    send_item(FUNC_ENC, {-16'sd16384, 16'sd1, -16'sd1, 16'sd0}, 2'd0, '0);
    send_item(FUNC_ENC, {16'sd8192, 16'sd8192, -16'sd8192, -16'sd8192}, 2'd0, '0);
    for (int d = 0; d < 4; d++) begin
      send_item(FUNC_DEC, {4{16'hffff}}, d[1:0], {3{MAXQ}});
      send_item(FUNC_DEC, '0, d[1:0], '0);
      send_item(FUNC_DEC, '0, d[1:0], {3{15'd16384}});
      send_item(FUNC_DEC, '0, d[1:0], {15'd16383, 15'd0, MAXQ});
    end

    // random, three idling phases, with a drain pause between
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 28 : (ph == 1) ? 73 : 0;
      for (int i = 0; i < 415; i++) begin
        for (int j = 0; j < 4; j++) q[j] = rand_comp();
        for (int j = 0; j < 3; j++) cd[j] = rand_code();
        send_item(func_e'($urandom_range(1)), q, 2'($urandom), cd);
      end
      start <= 1'b0;
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0)
      $display("** quaternion_smallest_three_codec: PASSED **");
    else
      $display("** quaternion_smallest_three_codec: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
design/qstc_pkg.sv
design/quaternion_smallest_three_codec.sv
tb/sv/qstc_checker.sv
tb/sv/tb.sv
